// File: hw/rtl/rti_pkg.sv
package rti_pkg;

  localparam int MAX_DEPTH   = 31;
  localparam int DEPTH_W     = 5;
  localparam int NSP_W       = 6;
  localparam int SPL_W       = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int WPOS_W      = 3;

  localparam logic [SPL_W-1:0] SPL_RESET = 2'd2;
  localparam logic [SPL_W-1:0] SPL_MAX   = 2'd2;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;

  localparam logic [WPOS_W-1:0] WORD_RET_LEN = 3'd6;

  // one request handed from classifier to emitter
  typedef struct packed {
    logic [7:0]       data;
    logic             brk_pre;
    logic             brk_post;
    logic [NSP_W-1:0] nsp;
  } rti_cmd_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } rti_back_sts_t;

endpackage

// File: hw/rtl/rti_ifs.sv
interface rti_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface rti_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface

interface rti_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] spaces_per_level;
  modport source (output valid, output spaces_per_level, input ready);
  modport sink (input valid, input spaces_per_level, output ready);
endinterface

// File: hw/rtl/rti_front.sv
module rti_front (
  input  logic              clk,
  input  logic              rst_n,
  rti_in_if.sink            in_ch,
  rti_cfg_if.sink           cfg_ch,
  input  logic              q_full,
  output logic              q_push,
  output rti_pkg::rti_cmd_t q_cmd
);
  import rti_pkg::*;

  logic [SPL_W-1:0]   spl_r;
  logic [DEPTH_W-1:0] depth_r, depth_nxt, dep_use;
  logic               dq_r, dq_nxt;
  logic               sq_r, sq_nxt;
  logic               rx_r, rx_nxt;
  logic               cc_r, cc_nxt;
  logic               skip_r, skip_nxt;
  logic [7:0]         prev_r;
  logic [WPOS_W-1:0]  wpos_r, wpos_nxt;
  logic               wother_r, wother_nxt;

  logic [7:0]       c;
  logic             quoted, word_empty, word_is_ret, esc;
  logic             pre, post;
  logic [SPL_W-1:0] sp_eff;
  logic [NSP_W-1:0] nsp;

  function automatic logic is_word_byte(input logic [7:0] b);
    return (b >= CH_0 && b <= CH_9) || (b >= CH_LA && b <= CH_LZ) ||
           (b >= CH_UA && b <= CH_UZ) || b == CH_USCORE;
  endfunction

  function automatic logic is_space_byte(input logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic [7:0] ret_char(input logic [WPOS_W-1:0] pos);
    logic [7:0] r;
    unique case (pos)
      3'd0:    r = 8'h72;
      3'd1:    r = 8'h65;
      3'd2:    r = 8'h74;
      3'd3:    r = 8'h75;
      3'd4:    r = 8'h72;
      3'd5:    r = 8'h6E;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  assign c           = in_ch.in_byte;
  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign cfg_ch.ready = 1'b1;

  assign quoted      = dq_r || sq_r || rx_r;
  assign word_empty  = (wpos_r == '0) && !wother_r;
  assign word_is_ret = (wpos_r == WORD_RET_LEN) && !wother_r;
  assign esc         = prev_r == CH_BSLASH;

  always_comb begin
    depth_nxt = depth_r;
    dep_use   = depth_r;
    dq_nxt    = dq_r;
    sq_nxt    = sq_r;
    rx_nxt    = rx_r;
    cc_nxt    = cc_r;
    skip_nxt  = skip_r;
    pre       = 1'b0;
    post      = 1'b0;
    unique case (c)
      CH_SEMI: begin
        post = !quoted;
      end
      CH_LBRACE: begin
        if (!quoted) begin
          if (word_is_ret) begin
            skip_nxt = 1'b1;
          end else begin
            pre = 1'b1;
            if (depth_r < DEPTH_W'(MAX_DEPTH)) depth_nxt = depth_r + 1'b1;
          end
        end
      end
      CH_RBRACE: begin
        if (!quoted && !skip_r) begin
          if (depth_r != '0) depth_nxt = depth_r - 1'b1;
          dep_use = depth_nxt;
          pre = prev_r != CH_LBRACE;
        end
      end
      CH_DQUOTE: begin
        if (!sq_r && !rx_r && !esc && !cc_r) dq_nxt = !dq_r;
      end
      CH_SQUOTE: begin
        if (!dq_r && !rx_r) sq_nxt = !sq_r;
      end
      CH_SLASH: begin
        if (!sq_r && !dq_r && !esc && !cc_r) begin
          if (!rx_r) begin
            if (word_empty || word_is_ret) rx_nxt = 1'b1;
          end else begin
            rx_nxt = 1'b0;
          end
        end
      end
      CH_LBRACK: begin
        if (rx_r && !esc) cc_nxt = 1'b1;
      end
      CH_RBRACK: begin
        if (cc_r && !esc) cc_nxt = 1'b0;
      end
      default: begin
        pre = (prev_r == CH_RBRACE || prev_r == CH_LBRACE) && !quoted && !skip_r;
        if (prev_r == CH_RBRACE && skip_r) skip_nxt = 1'b0;
      end
    endcase
  end

  always_comb begin
    wpos_nxt   = wpos_r;
    wother_nxt = wother_r;
    if (is_word_byte(c)) begin
      if (!wother_r) begin
        if (wpos_r < WORD_RET_LEN && c == ret_char(wpos_r)) wpos_nxt = wpos_r + 1'b1;
        else wother_nxt = 1'b1;
      end
    end else if (!is_space_byte(c)) begin
      wpos_nxt   = '0;
      wother_nxt = 1'b0;
    end
  end

  assign sp_eff = (spl_r > SPL_MAX) ? SPL_MAX : spl_r;

  always_comb begin
    unique case (sp_eff)
      2'd0:    nsp = '0;
      2'd1:    nsp = NSP_W'(dep_use);
      default: nsp = NSP_W'({dep_use, 1'b0});
    endcase
  end

  assign q_cmd.data     = c;
  assign q_cmd.brk_pre  = pre;
  assign q_cmd.brk_post = post;
  assign q_cmd.nsp      = nsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spl_r    <= SPL_RESET;
      depth_r  <= '0;
      dq_r     <= 1'b0;
      sq_r     <= 1'b0;
      rx_r     <= 1'b0;
      cc_r     <= 1'b0;
      skip_r   <= 1'b0;
      prev_r   <= '0;
      wpos_r   <= '0;
      wother_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) spl_r <= cfg_ch.spaces_per_level;
      if (q_push) begin
        depth_r  <= depth_nxt;
        dq_r     <= dq_nxt;
        sq_r     <= sq_nxt;
        rx_r     <= rx_nxt;
        cc_r     <= cc_nxt;
        skip_r   <= skip_nxt;
        prev_r   <= c;
        wpos_r   <= wpos_nxt;
        wother_r <= wother_nxt;
      end
    end
  end

endmodule

// File: hw/rtl/rti_queue.sv
module rti_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  rti_pkg::rti_cmd_t          push_cmd,
  input  logic                       pop,
  output logic                       full,
  output logic                       empty,
  output logic [rti_pkg::QCNT_W-1:0] count,
  output rti_pkg::rti_cmd_t          head
);
  import rti_pkg::*;

  rti_cmd_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full  = cnt_r == QCNT_W'(QUEUE_DEPTH);
  assign empty = cnt_r == '0;
  assign count = cnt_r;
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// File: hw/rtl/rti_back.sv
module rti_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  rti_pkg::rti_cmd_t     q_head,
  rti_out_if.source             out_ch,
  output rti_pkg::rti_back_sts_t sts
);
  import rti_pkg::*;

  typedef enum logic [4:0] {
    ST_START   = 5'b00001,
    ST_PRE_SP  = 5'b00010,
    ST_BYTE    = 5'b00100,
    ST_POST_NL = 5'b01000,
    ST_POST_SP = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [NSP_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;
  logic             adv, emit, pop;

  assign adv = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    emit         = 1'b0;
    pop          = 1'b0;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;
    if (adv && !q_empty) begin
      emit = 1'b1;
      unique case (state_r)
        ST_START: begin
          if (q_head.brk_pre) begin
            out_byte_nxt = CH_LF;
            out_last_nxt = 1'b0;
            cnt_nxt      = q_head.nsp;
            state_nxt    = (q_head.nsp != '0) ? ST_PRE_SP : ST_BYTE;
          end else begin
            out_byte_nxt = q_head.data;
            out_last_nxt = !q_head.brk_post;
            if (q_head.brk_post) state_nxt = ST_POST_NL;
            else pop = 1'b1;
          end
        end
        ST_PRE_SP: begin
          out_byte_nxt = CH_SPACE;
          out_last_nxt = 1'b0;
          cnt_nxt      = cnt_r - 1'b1;
          if (cnt_r == NSP_W'(1)) state_nxt = ST_BYTE;
        end
        ST_BYTE: begin
          out_byte_nxt = q_head.data;
          out_last_nxt = !q_head.brk_post;
          if (q_head.brk_post) begin
            state_nxt = ST_POST_NL;
          end else begin
            pop       = 1'b1;
            state_nxt = ST_START;
          end
        end
        ST_POST_NL: begin
          out_byte_nxt = CH_LF;
          out_last_nxt = q_head.nsp == '0;
          cnt_nxt      = q_head.nsp;
          if (q_head.nsp == '0) begin
            pop       = 1'b1;
            state_nxt = ST_START;
          end else begin
            state_nxt = ST_POST_SP;
          end
        end
        ST_POST_SP: begin
          out_byte_nxt = CH_SPACE;
          out_last_nxt = cnt_r == NSP_W'(1);
          cnt_nxt      = cnt_r - 1'b1;
          if (cnt_r == NSP_W'(1)) begin
            pop       = 1'b1;
            state_nxt = ST_START;
          end
        end
        default: begin
          emit      = 1'b0;
          state_nxt = ST_START;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_START;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.last     = out_last_r;
  assign sts.busy        = state_r != ST_START;
  assign sts.pop         = pop;

endmodule

// File: hw/rtl/script_text_reindenter.sv
// Path: an accepted byte is written into the request queue, then the emitter registers its results onto out_ch.
// Throughput: one output byte per cycle from the emitter while out_ch is ready; an input byte that causes
// N results (1 to 64: newline, indentation spaces, the byte) holds the emitter until all N are out.
// The classifier takes one byte per cycle until the two-entry request queue fills.
// Reset (rst_n low, synchronous): depth, literal modes, word tracking and queue cleared,
// spaces_per_level returns to 2, out_ch.valid drops.
module script_text_reindenter (
  input logic       clk,
  input logic       rst_n,
  rti_in_if.sink    in_ch,
  rti_out_if.source out_ch,
  rti_cfg_if.sink   cfg_ch
);
  import rti_pkg::*;

  logic              q_push, q_full, q_empty;
  logic [QCNT_W-1:0] q_count;
  rti_cmd_t          push_cmd, q_head;
  rti_back_sts_t     back_sts;

  rti_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  rti_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (back_sts.pop),
    .full     (q_full),
    .empty    (q_empty),
    .count    (q_count),
    .head     (q_head)
  );

  rti_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .out_ch  (out_ch),
    .sts     (back_sts)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= QCNT_W'(QUEUE_DEPTH))
    else $error("request queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    back_sts.pop |-> !q_empty)
    else $error("pop from empty request queue");

  a_mid_request: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.last) |-> back_sts.busy)
    else $error("non-final output byte while emitter idle");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid right after reset");

endmodule

// File: tb/script_text_reindenter_tb.sv
`timescale 1ns / 1ps

module script_text_reindenter_tb;
  import rti_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_LIMIT = 20_000;
  localparam logic [47:0] RET_WORD = "return";

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } emit_t;

  logic clk = 1'b0;
  logic rst_n;

  rti_in_if  in_ch();
  rti_out_if out_ch();
  rti_cfg_if cfg_ch();

  script_text_reindenter i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected output bytes, oldest first
  emit_t exp_q[$];
  int unsigned err_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_cnt;

  // indenter state mirror
  logic [DEPTH_W-1:0] lvl;
  logic               in_dq, in_sq, in_re, in_cls, skipping, word_odd;
  logic [7:0]         prev_ch;
  logic [WPOS_W-1:0]  ret_pos;
  logic [SPL_W-1:0]   spacing;

  function automatic void reset_indenter();
    lvl = '0;
    in_dq = 1'b0;
    in_sq = 1'b0;
    in_re = 1'b0;
    in_cls = 1'b0;
    skipping = 1'b0;
    word_odd = 1'b0;
    prev_ch = '0;
    ret_pos = '0;
    spacing = SPL_RESET;
  endfunction

  function automatic void emit(input logic [7:0] b);
    exp_q.push_back('{data: b, last: 1'b0});
  endfunction

  function automatic void emit_break();
    int unsigned total;
    total = lvl * ((spacing > SPL_MAX) ? SPL_MAX : spacing);
    emit(CH_LF);
    repeat (total) emit(CH_SPACE);
  endfunction

  function automatic logic is_word_ch(input logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LZ) ||
           (c >= CH_UA && c <= CH_UZ) || c == CH_USCORE;
  endfunction

  function automatic logic is_blank_ch(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic void predict_byte(input logic [7:0] c);
    logic quoted, word_empty, word_ret, esc;
    quoted = in_dq | in_sq | in_re;
    word_empty = ret_pos == 0 && !word_odd;
    word_ret = ret_pos == WORD_RET_LEN && !word_odd;
    esc = prev_ch == CH_BSLASH;
    case (c)
      CH_SEMI: begin
        emit(c);
        if (!quoted) emit_break();
      end
      CH_LBRACE: begin
        if (!quoted) begin
          if (word_ret) begin
            skipping = 1'b1;
          end else begin
            emit_break();
            if (lvl < MAX_DEPTH) lvl++;
          end
        end
        emit(c);
      end
      CH_RBRACE: begin
        if (!quoted && !skipping) begin
          if (lvl != 0) lvl--;
          if (prev_ch != CH_LBRACE) emit_break();
        end
        emit(c);
      end
      CH_DQUOTE: begin
        if (!in_sq && !in_re && !esc && !in_cls) in_dq = !in_dq;
        emit(c);
      end
      CH_SQUOTE: begin
        if (!in_dq && !in_re) in_sq = !in_sq;
        emit(c);
      end
      CH_SLASH: begin
        if (!in_sq && !in_dq && !esc && !in_cls) begin
          if (!in_re) begin
            if (word_empty || word_ret) in_re = 1'b1;
          end else begin
            in_re = 1'b0;
          end
        end
        emit(c);
      end
      CH_LBRACK: begin
        if (in_re && !esc) in_cls = 1'b1;
        emit(c);
      end
      CH_RBRACK: begin
        if (in_cls && !esc) in_cls = 1'b0;
        emit(c);
      end
      default: begin
        if ((prev_ch == CH_RBRACE || prev_ch == CH_LBRACE) && !quoted && !skipping)
          emit_break();
        emit(c);
        if (prev_ch == CH_RBRACE && skipping) skipping = 1'b0;
      end
    endcase
    prev_ch = c;
    if (is_word_ch(c)) begin
      if (!word_odd) begin
        if (ret_pos < WORD_RET_LEN && c == RET_WORD[8*(5-ret_pos) +: 8]) ret_pos++;
        else word_odd = 1'b1;
      end
    end else if (!is_blank_ch(c)) begin
      ret_pos = '0;
      word_odd = 1'b0;
    end
    exp_q[exp_q.size()-1].last = 1'b1;
  endfunction

  function automatic void note_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%0t: %s", $time, msg);
  endfunction

  function automatic void check_result(input logic [7:0] b, input logic l);
    emit_t e;
    if (exp_q.size() == 0) begin
      note_error($sformatf("unexpected byte 0x%02h last %0b", b, l));
      return;
    end
    e = exp_q.pop_front();
    if (e.data !== b || e.last !== l)
      note_error($sformatf("byte exp 0x%02h got 0x%02h, last exp %0b got %0b",
                           e.data, b, e.last, l));
  endfunction

  always @(posedge clk) begin : scoreboard
    if (!rst_n) begin
      reset_indenter();
      exp_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) spacing = cfg_ch.spaces_per_level;
      if (in_ch.valid && in_ch.ready) predict_byte(in_ch.in_byte);
      if (out_ch.valid && out_ch.ready) check_result(out_ch.out_byte, out_ch.last);
    end
  end

  always @(posedge clk) begin : receiver
    if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("script_text_reindenter_tb NOT OK");
    $finish;
  end

  // valid stays high from one request to the next unless an idle cycle comes
  task automatic send_byte(input logic [7:0] b);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_quiet();
    int unsigned waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (exp_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic set_spacing(input logic [SPL_W-1:0] v);
    wait_quiet();
    cfg_ch.valid <= 1'b1;
    cfg_ch.spaces_per_level <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [7:0] rand_word_ch();
    int unsigned r;
    r = $urandom_range(62);
    if (r < 10) return 8'(CH_0 + r);
    if (r < 36) return 8'(CH_LA + (r - 10));
    if (r < 62) return 8'(CH_UA + (r - 36));
    return CH_USCORE;
  endfunction

  function automatic logic [7:0] rand_lit_ch();
    case ($urandom_range(9))
      0: return CH_BSLASH;
      1: return CH_DQUOTE;
      2: return CH_SQUOTE;
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  function automatic logic [7:0] rand_regex_ch();
    case ($urandom_range(9))
      0: return CH_BSLASH;
      1: return CH_LBRACK;
      2: return CH_RBRACK;
      3: return CH_SLASH;
      default: return rand_word_ch();
    endcase
  endfunction

  task automatic send_token();
    int unsigned kind;
    logic [7:0] quote;
    kind = $urandom_range(99);
    if (kind < 25) begin
      repeat ($urandom_range(1, 6)) send_byte(rand_word_ch());
    end else if (kind < 33) begin
      send_byte($urandom_range(5) == 5 ? CH_SPACE : 8'(CH_TAB + $urandom_range(4)));
    end else if (kind < 43) begin
      send_byte(CH_SEMI);
    end else if (kind < 53) begin
      send_byte(CH_LBRACE);
    end else if (kind < 63) begin
      send_byte(CH_RBRACE);
    end else if (kind < 71) begin
      send_text("return");
      if ($urandom_range(1)) send_byte(CH_SPACE);
      send_byte($urandom_range(1) ? CH_LBRACE : CH_SLASH);
    end else if (kind < 80) begin
      quote = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
      send_byte(quote);
      repeat ($urandom_range(4)) send_byte(rand_lit_ch());
      send_byte(quote);
    end else if (kind < 88) begin
      send_byte(CH_SLASH);
      repeat ($urandom_range(5)) send_byte(rand_regex_ch());
      send_byte(CH_SLASH);
    end else begin
      send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic send_script(input int unsigned n_items);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < n_items) send_token();
  endtask

  task automatic test_literals();
    send_text("a/b=/[/]\\//;");
    send_text("\"\\\";'\"'x';");
  endtask

  task automatic test_words_and_blocks();
    send_text("}return{;}z");
    send_text("{");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("}return /r/");
  endtask

  task automatic test_depth_extremes();
    set_spacing(2'd3);
    repeat (MAX_DEPTH + 2) send_byte(CH_LBRACE);
    send_text("x");
    repeat (MAX_DEPTH + 2) send_byte(CH_RBRACE);
    send_byte(CH_SEMI);
  endtask

  task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                     input logic [SPL_W-1:0] spl, input int unsigned n_items);
    set_spacing(spl);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    send_script(n_items);
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    set_spacing(2'd1);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_left = 300;
    send_text("{{a;b}c;{d}}");
    send_script(20);
  endtask

  initial begin : main
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.spaces_per_level = SPL_RESET;
    out_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_literals();
    test_words_and_blocks();
    test_depth_extremes();
    test_random_traffic(0, 0, 2'd0, 20);
    test_random_traffic(60, 0, 2'd2, 20);
    test_random_traffic(0, 60, 2'd1, 20);
    test_random_traffic(32, 32, SPL_W'($urandom_range(3)), 20);
    test_backpressure();

    wait_quiet();
    if (exp_q.size() != 0)
      note_error($sformatf("%0d expected bytes never came out", exp_q.size()));
    if (err_cnt == 0) begin
      $display("script_text_reindenter_tb OK");
    end else begin
      $display("script_text_reindenter_tb NOT OK");
    end
    $finish;
  end

endmodule
